@@ rtl/core/lph_pkg.sv @@
// Package for the looping playhead counter.
// Holds field widths, register indexes, operation codes and reset values.
// No dependencies.
package lph_pkg;

  localparam int FRAME_BITS_DEF = 16;
  localparam int AMOUNT_W       = 18;
  localparam int OUT_FRAME_W    = 16;
  localparam int DUR_W          = 16;
  localparam int OFFSET_W       = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION = 2'd0,
    REG_LOOP     = 2'd1,
    REG_SWING    = 2'd2,
    REG_OFFSET   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_SEEK    = 1'b1
  } op_e;

endpackage

@@ rtl/core/lph_divmod.sv @@
// Iterative restoring remainder unit, one dividend bit per cycle.
// Used by the looping playhead counter; no package dependencies.
module lph_divmod #(
  parameter int DW = 20,
  parameter int MW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [MW-1:0] divisor_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic          active_q, active_d;
  logic          done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [MW-1:0] dsr_q, dsr_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [MW:0]   trial;

  assign trial = {rem_q, dvd_q[DW-1]};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    rem_d    = rem_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = CNT_W'(DW - 1);
      dvd_d    = dividend_i;
      dsr_d    = divisor_i;
      rem_d    = '0;
    end else if (active_q) begin
      // subtract when the partial remainder reaches the divisor
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = MW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[MW-1:0];
      end
      dvd_d = dvd_q << 1;
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/looping_playhead_counter.sv @@
// Looping playhead counter: top level with sequencer and configuration registers.
// Depends on lph_pkg and lph_divmod.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, operation_i, amount_i | sink
//  out     | out_valid_o, out_ready_i, frame_o, backward_o | source
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | sink
//
// When looping with a non-negative position an item goes through DIV, where
// the bit-serial remainder unit takes one bit of the raw position per cycle,
// then FIN; clamping or negative positions skip DIV. in_ready_o is high
// only in IDLE. A finished result waits in the output register; the next item
// may be taken meanwhile and stalls in FIN until the output is free.
// Reset: duration 500, looping and swing off, offset 0, playhead 0 forward.
module looping_playhead_counter #(
  parameter int FRAME_BITS = lph_pkg::FRAME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic signed [lph_pkg::AMOUNT_W-1:0] amount_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lph_pkg::OUT_FRAME_W-1:0]    frame_o,
  output logic                               backward_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lph_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lph_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import lph_pkg::*;

  localparam int FB = FRAME_BITS;
  localparam int VW = (FB + 3 > 20) ? FB + 3 : 20;
  localparam int MW = FB + 1;
  localparam int CW = (FB > DUR_W) ? FB : DUR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q;

  logic [DUR_W-1:0]           dur_q;
  logic                       loop_q, swing_q;
  logic signed [OFFSET_W-1:0] offset_q;

  logic [FB-1:0]        playhead_q;
  logic                 back_q;
  logic signed [VW-1:0] v_q;
  logic [MW-1:0]        divisor_q;

  logic [OUT_FRAME_W-1:0] frame_q;
  logic                   backward_q;
  logic                   out_valid_q;

  // Effective duration, swing half period and divisors
  logic [CW-1:0] dur_w;
  logic [FB-1:0] dur_eff, d_sw;
  logic [MW-1:0] period, mod_plain;

  assign dur_w     = CW'(dur_q);
  assign dur_eff   = (dur_w > CW'({FB{1'b1}})) ? {FB{1'b1}} : dur_w[FB-1:0];
  assign d_sw      = (dur_eff == '0) ? FB'(1) : dur_eff;
  assign period    = {d_sw, 1'b0};
  assign mod_plain = MW'({1'b0, dur_eff}) + MW'(1);

  // Raw position on accept
  logic signed [VW-1:0] phase, v_new;
  logic                 swing_on, in_xfer;

  assign swing_on = loop_q && swing_q;
  assign in_xfer  = in_valid_i && in_ready_o;

  always_comb begin
    if (back_q) begin
      phase = $signed(VW'({1'b0, period})) - $signed(VW'({1'b0, playhead_q}));
    end else begin
      phase = $signed(VW'({1'b0, playhead_q}));
    end
    if (op_e'(operation_i) == OP_SEEK) begin
      v_new = VW'(amount_i) - VW'(offset_q);
    end else if (swing_on) begin
      v_new = phase + VW'(amount_i);
    end else begin
      v_new = $signed(VW'({1'b0, playhead_q})) + VW'(amount_i);
    end
  end

  // Remainder unit
  logic          div_start, div_done;
  logic [MW-1:0] rem;

  assign div_start = in_xfer && loop_q && !v_new[VW-1];

  lph_divmod #(
    .DW(VW - 1),
    .MW(MW)
  ) u_divmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(v_new[VW-2:0]),
    .divisor_i (divisor_q),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  assign divisor_q = swing_q ? period : mod_plain;

  // Resolve the position into a frame and direction
  logic [FB-1:0] f_res;
  logic          b_res;

  always_comb begin
    f_res = '0;
    b_res = 1'b0;
    if (v_q[VW-1]) begin
      f_res = '0;
    end else if (!loop_q) begin
      if (v_q > $signed(VW'({1'b0, dur_eff}))) begin
        f_res = dur_eff;
      end else begin
        f_res = v_q[FB-1:0];
      end
    end else if (!swing_q) begin
      f_res = rem[FB-1:0];
    end else if (rem == '0) begin
      f_res = '0;
    end else if (rem == {1'b0, d_sw}) begin
      f_res = d_sw;
      b_res = 1'b1;
    end else if (rem < {1'b0, d_sw}) begin
      f_res = rem[FB-1:0];
    end else begin
      f_res = FB'(period - rem);
      b_res = 1'b1;
    end
  end

  logic out_free, fin_fire;
  assign out_free = !out_valid_q || out_ready_i;
  assign fin_fire = (state_q == S_FIN) && out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q    <= DUR_RESET;
      loop_q   <= 1'b0;
      swing_q  <= 1'b0;
      offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DURATION: dur_q    <= cfg_data_i[DUR_W-1:0];
        REG_LOOP:     loop_q   <= cfg_data_i[0];
        REG_SWING:    swing_q  <= cfg_data_i[0];
        REG_OFFSET:   offset_q <= $signed(cfg_data_i[OFFSET_W-1:0]);
        default:      ;
      endcase
    end
  end

  // Sequencer, playhead state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      playhead_q  <= '0;
      back_q      <= 1'b0;
      out_valid_q <= 1'b0;
      frame_q     <= '0;
      backward_q  <= 1'b0;
    end else begin
      // load a new result, or drop the old one once it is taken
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= div_start ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            playhead_q <= f_res;
            back_q     <= b_res;
            frame_q    <= OUT_FRAME_W'(f_res);
            backward_q <= b_res;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      v_q <= v_new;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign frame_o     = frame_q;
  assign backward_o  = backward_q;
  assign cfg_ready_o = 1'b1;

endmodule

@@ dv/looping_playhead_counter_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the looping playhead counter.
// Predicts frame and direction per transfer and scoreboards them in order.
// Depends on lph_pkg and the looping_playhead_counter RTL.
module looping_playhead_counter_tb;
  import lph_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 110;

  localparam logic signed [AMOUNT_W-1:0] AMT_MAX = {1'b0, {(AMOUNT_W-1){1'b1}}};
  localparam logic signed [AMOUNT_W-1:0] AMT_MIN = {1'b1, {(AMOUNT_W-1){1'b0}}};

  typedef struct packed {
    logic [OUT_FRAME_W-1:0] frame;
    logic                   backward;
  } frame_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  op_e                        operation_i;
  logic signed [AMOUNT_W-1:0] amount_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [OUT_FRAME_W-1:0]     frame_o;
  logic                       backward_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  cfg_reg_e                   cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;

  // Predictor copy of the registers and the playhead
  logic [DUR_W-1:0]           cfg_duration = DUR_RESET;
  logic                       cfg_loop     = 1'b0;
  logic                       cfg_swing    = 1'b0;
  logic signed [OFFSET_W-1:0] cfg_offset   = '0;
  logic [OUT_FRAME_W-1:0]     ph_frame     = '0;
  logic                       ph_back      = 1'b0;

  frame_result_t expected_frames[$];
  int            mismatch_count = 0;
  int            burst_left     = 0;
  bit            hold_req;

  looping_playhead_counter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .amount_i    (amount_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame_o),
    .backward_o  (backward_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Resolve a raw position into frame and direction
  function automatic void settle_position(longint pos);
    longint dur, d, period, w, f;
    dur = longint'(cfg_duration);
    ph_back = 1'b0;
    if (pos < 0) begin
      f = 0;
    end else if (!cfg_loop) begin
      f = (pos > dur) ? dur : pos;
    end else if (!cfg_swing) begin
      f = pos % (dur + 1);
    end else begin
      d = (dur < 1) ? 1 : dur;
      period = 2 * d;
      w = pos % period;
      if (w == 0) begin
        f = 0;
      end else if (w == d) begin
        f = d;
        ph_back = 1'b1;
      end else if (w < d) begin
        f = w;
      end else begin
        f = period - w;
        ph_back = 1'b1;
      end
    end
    ph_frame = OUT_FRAME_W'(f);
  endfunction

  function automatic frame_result_t step_playhead(op_e op, logic signed [AMOUNT_W-1:0] amt);
    longint a, d, phase;
    a = longint'(amt);
    if (op == OP_SEEK) begin
      settle_position(a - longint'(cfg_offset));
    end else if (!cfg_loop || !cfg_swing) begin
      settle_position(longint'(ph_frame) + a);
    end else begin
      // map a backward playhead to its phase in the swing period
      d = (cfg_duration < 1) ? 1 : longint'(cfg_duration);
      phase = ph_back ? 2 * d - longint'(ph_frame) : longint'(ph_frame);
      settle_position(phase + a);
    end
    return '{frame: ph_frame, backward: ph_back};
  endfunction

  // Mostly amounts that land near the range, some fully random
  function automatic logic signed [AMOUNT_W-1:0] pick_amount(op_e op);
    longint d, v;
    d = (cfg_duration < 1) ? 1 : longint'(cfg_duration);
    if ($urandom_range(0, 7) == 0) begin
      v = longint'($urandom());
    end else begin
      v = longint'($urandom_range(0, 32'(3 * d + 4))) - d - 2;
      if (op == OP_SEEK) v += longint'(cfg_offset) + d;
    end
    return v[AMOUNT_W-1:0];
  endfunction

  task automatic send_item(op_e op, logic signed [AMOUNT_W-1:0] amt);
    int            gap;
    frame_result_t exp_item;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 24);
      burst_left = $urandom_range(1, 20);
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    amount_i    <= amt;
    do @(posedge clk_i); while (!in_ready_o);
    exp_item = step_playhead(op, amt);
    expected_frames.insert(expected_frames.size(), exp_item);
  endtask

  task automatic send_random_item();
    op_e op;
    op = op_e'($urandom_range(0, 1));
    send_item(op, pick_amount(op));
  endtask

  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DURATION: cfg_duration = data;
      REG_LOOP:     cfg_loop = data[0];
      REG_SWING:    cfg_swing = data[0];
      REG_OFFSET:   cfg_offset = data;
      default: ;
    endcase
  endtask

  // Write all registers; flag registers carry noise in the unused bits
  task automatic set_config(int dur, bit loop_on, bit swing_on, int ofs);
    logic [CFG_DATA_W-1:0] noise;
    wait_idle();
    noise = CFG_DATA_W'($urandom());
    write_reg(REG_DURATION, CFG_DATA_W'(dur));
    write_reg(REG_LOOP, {noise[CFG_DATA_W-1:1], loop_on});
    noise = CFG_DATA_W'($urandom());
    write_reg(REG_SWING, {noise[CFG_DATA_W-1:1], swing_on});
    write_reg(REG_OFFSET, CFG_DATA_W'(ofs));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_clamp_at_reset();
    send_item(OP_ADVANCE, AMOUNT_W'(0));
    send_item(OP_ADVANCE, AMT_MAX);
    send_item(OP_ADVANCE, AMT_MIN);
    send_item(OP_SEEK, AMOUNT_W'(250));
    send_item(OP_ADVANCE, AMOUNT_W'(-1));
    send_item(OP_SEEK, AMOUNT_W'(-1));
    send_item(OP_SEEK, AMT_MAX);
  endtask

  task automatic test_plain_wrap();
    set_config(9, 1'b1, 1'b0, 0);
    send_item(OP_SEEK, AMOUNT_W'(9));
    send_item(OP_ADVANCE, AMOUNT_W'(1));
    send_item(OP_ADVANCE, AMOUNT_W'(25));
    send_item(OP_ADVANCE, AMOUNT_W'(-6));
    send_item(OP_SEEK, AMT_MAX);
    set_config(0, 1'b1, 1'b0, 0);
    send_item(OP_ADVANCE, AMOUNT_W'(7));
  endtask

  task automatic test_swing_bounce();
    set_config(4, 1'b1, 1'b1, 3);
    send_item(OP_SEEK, AMOUNT_W'(3));
    send_item(OP_SEEK, AMOUNT_W'(7));
    send_item(OP_ADVANCE, AMOUNT_W'(1));
    send_item(OP_ADVANCE, AMOUNT_W'(3));
    send_item(OP_ADVANCE, AMOUNT_W'(6));
    send_item(OP_ADVANCE, AMOUNT_W'(-7));
    // zero duration swings over a period of two
    set_config(0, 1'b1, 1'b1, 3);
    send_item(OP_SEEK, AMOUNT_W'(4));
    send_item(OP_ADVANCE, AMOUNT_W'(1));
    // shrink the range under a backward playhead
    set_config(1000, 1'b1, 1'b1, 0);
    send_item(OP_SEEK, AMOUNT_W'(1500));
    set_config(10, 1'b1, 1'b1, 0);
    send_item(OP_ADVANCE, AMOUNT_W'(5));
    // swing without looping clamps
    set_config(10, 1'b0, 1'b1, 0);
    send_item(OP_ADVANCE, AMOUNT_W'(25));
  endtask

  task automatic test_offset_extremes();
    set_config(65535, 1'b1, 1'b0, -32768);
    send_item(OP_SEEK, AMT_MAX);
    set_config(65535, 1'b1, 1'b1, 32767);
    send_item(OP_SEEK, AMT_MIN);
    send_item(OP_SEEK, AMT_MAX);
    send_item(OP_ADVANCE, AMT_MAX);
    set_config(65535, 1'b0, 1'b0, -32768);
    send_item(OP_SEEK, AMT_MAX);
    send_item(OP_ADVANCE, AMT_MIN);
  endtask

  // Hold the output for a long stretch while transfers keep being offered
  task automatic test_output_backpressure();
    set_config(50, 1'b1, 1'b1, 0);
    hold_req = 1'b1;
    burst_left = 12;
    repeat (12) send_random_item();
  endtask

  task automatic test_random_phases();
    int dur, ofs;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: dur = 0;
        1: dur = 1;
        2: dur = 65535;
        3: dur = $urandom_range(2, 20);
        4: dur = $urandom_range(21, 3000);
        default: dur = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 4))
        0: ofs = -32768;
        1: ofs = 32767;
        2: ofs = 0;
        default: ofs = $urandom_range(0, 400) - 200;
      endcase
      set_config(dur, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), ofs);
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  // Result scoreboard
  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        $error("frame: expected none, got %0d", frame_o);
        mismatch_count++;
      end else begin
        exp_r = expected_frames.pop_front();
        if (frame_o !== exp_r.frame) begin
          $error("frame: expected %0d, got %0d", exp_r.frame, frame_o);
          mismatch_count++;
        end
        if (backward_o !== exp_r.backward) begin
          $error("backward: expected %0d, got %0d", exp_r.backward, backward_o);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: stall modes of random span, plus the requested long hold
  initial begin
    int hold_left, span_left, mode;
    out_ready_i = 1'b0;
    hold_left = 0;
    span_left = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (span_left == 0) begin
        mode = $urandom_range(0, 3);
        span_left = $urandom_range(16, 160);
      end
      span_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_ADVANCE;
    amount_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DURATION;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_clamp_at_reset();
    test_plain_wrap();
    test_swing_bounce();
    test_offset_extremes();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lph_pkg.sv
rtl/core/lph_divmod.sv
rtl/core/looping_playhead_counter.sv
dv/looping_playhead_counter_tb.sv
